### rtl/stuffed_frame_receiver_top_assert.svh
// Assertion macros for the frame receiver RTL.
// Used by sfr_rsp_queue to check its own control logic; no other dependencies.
`ifndef STUFFED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sfr_pkg.sv
// Package for the stuffed frame receiver: codes, result and control structs.
// No dependencies; used by every module of the block.
package sfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int CSR_INDEX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] FLAG_BYTE  = 8'h7E;
   localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7D;
   localparam logic [BYTE_W-1:0] CTRL_I0    = 8'h00;
   localparam logic [BYTE_W-1:0] CTRL_I1    = 8'h40;
   localparam logic [BYTE_W-1:0] CTRL_DISC  = 8'h0B;
   localparam logic [6:0]        RR_BASE    = 7'h05;
   localparam logic [BYTE_W-1:0] STUFF_XOR  = 8'h20;
   localparam logic [BYTE_W-1:0] ESC_FLAG   = 8'h5E;
   localparam logic [BYTE_W-1:0] ESC_ESC    = 8'h5D;
   localparam logic [LEN_W-1:0]  LEN_MAX    = '1;

   localparam logic [BYTE_W-1:0] FRAME_ADDRESS_RESET = 8'h03;
   localparam logic [BYTE_W-1:0] REPLY_ADDRESS_RESET = 8'h01;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLY_ADDRESS = 2'd1;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_FLAG,
      ST_ADDR,
      ST_CTRL,
      ST_DATA,
      ST_ESC
   } parse_state_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_GOOD,
      KIND_ERROR,
      KIND_DISC
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_seq;
      logic [BYTE_W-1:0] reply_control;
      logic              last;
   } rsp_type;

   // Results produced by one transaction: zero, one or two entries.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } push_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_address;
      logic [BYTE_W-1:0] reply_address;
   } cfg_type;

   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] value);
      sat_inc = (value == LEN_MAX) ? value : value + 1'b1;
   endfunction

endpackage

### rtl/sfr_csr.sv
// Configuration registers of the stuffed frame receiver.
// Depends on sfr_pkg for the register index codes and the cfg_type struct.
module sfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]       csr_wdata,
   output sfr_pkg::cfg_type                 cfg
);

   sfr_pkg::cfg_type cfg_ff;
   sfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            sfr_pkg::CSR_FRAME_ADDRESS: cfg_in.frame_address = csr_wdata;
            sfr_pkg::CSR_REPLY_ADDRESS: cfg_in.reply_address = csr_wdata;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_address <= sfr_pkg::FRAME_ADDRESS_RESET;
         cfg_ff.reply_address <= sfr_pkg::REPLY_ADDRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/sfr_parser.sv
// Input register and frame parser: header checks, destuffing, BCC2 check.
// Depends on sfr_pkg; produces up to two results per transaction for sfr_rsp_queue.
module sfr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]  req_rx_byte,
   input  sfr_pkg::cfg_type            cfg,
   input  logic                        queue_room,
   output sfr_pkg::push_type           push
);

   logic                       in_valid_ff, in_valid_in;
   logic [sfr_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;

   sfr_pkg::parse_state_type   state_ff, state_in;
   logic [sfr_pkg::BYTE_W-1:0] control_ff, control_in;
   logic [sfr_pkg::BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic                       held_valid_ff, held_valid_in;
   logic [sfr_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic [sfr_pkg::LEN_W-1:0]  count_ff, count_in;
   logic                       reply_seq_ff, reply_seq_in;

   logic                       accept;
   logic                       fire;
   logic [sfr_pkg::BYTE_W-1:0] b;
   logic                       is_info_ctrl;
   logic                       bcc1_ok;
   logic                       esc_ok;
   logic [sfr_pkg::BYTE_W-1:0] push_value;
   sfr_pkg::push_type          push_c;

   assign b            = in_byte_ff;
   assign fire         = in_valid_ff && queue_room;
   assign req_stall    = in_valid_ff && !queue_room;
   assign accept       = req_valid && !req_stall;
   assign is_info_ctrl = (b == sfr_pkg::CTRL_I0) || (b == sfr_pkg::CTRL_I1);
   assign bcc1_ok      = (b == (cfg.frame_address ^ control_ff)) ||
                         (b == (cfg.reply_address ^ control_ff));
   assign esc_ok       = (b == sfr_pkg::ESC_FLAG) || (b == sfr_pkg::ESC_ESC);
   assign push_value   = (state_ff == sfr_pkg::ST_ESC) ? (b ^ sfr_pkg::STUFF_XOR) : b;

   // Input register: hold while the queue lacks room for two results.
   always_comb begin
      in_byte_in  = accept ? req_rx_byte : in_byte_ff;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   end

   // Next parse state.
   always_comb begin
      state_in = state_ff;
      if (fire) begin
         unique case (state_ff)
            sfr_pkg::ST_HUNT: begin
               if (b == sfr_pkg::FLAG_BYTE) state_in = sfr_pkg::ST_FLAG;
            end
            sfr_pkg::ST_FLAG: begin
               // address match wins over the flag test
               if (b == cfg.frame_address)       state_in = sfr_pkg::ST_ADDR;
               else if (b != sfr_pkg::FLAG_BYTE) state_in = sfr_pkg::ST_HUNT;
            end
            sfr_pkg::ST_ADDR: begin
               if (is_info_ctrl)                 state_in = sfr_pkg::ST_CTRL;
               else if (b == sfr_pkg::FLAG_BYTE) state_in = sfr_pkg::ST_FLAG;
               else                              state_in = sfr_pkg::ST_HUNT;
            end
            sfr_pkg::ST_CTRL: begin
               if (bcc1_ok)                      state_in = sfr_pkg::ST_DATA;
               else if (b == sfr_pkg::FLAG_BYTE) state_in = sfr_pkg::ST_FLAG;
               else                              state_in = sfr_pkg::ST_HUNT;
            end
            sfr_pkg::ST_DATA: begin
               if (b == sfr_pkg::ESC_BYTE)       state_in = sfr_pkg::ST_ESC;
               else if (b == sfr_pkg::FLAG_BYTE) state_in = sfr_pkg::ST_HUNT;
            end
            sfr_pkg::ST_ESC: begin
               state_in = sfr_pkg::ST_DATA;
            end
            default: state_in = sfr_pkg::ST_HUNT;
         endcase
      end
   end

   // Datapath and results.
   always_comb begin
      control_in    = control_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      xor_in        = xor_ff;
      count_in      = count_ff;
      reply_seq_in  = reply_seq_ff;
      push_c        = '0;
      if (fire) begin
         unique case (state_ff)
            sfr_pkg::ST_ADDR: begin
               if (is_info_ctrl) begin
                  control_in = b;
               end else if ((b != sfr_pkg::FLAG_BYTE) && (b == sfr_pkg::CTRL_DISC)) begin
                  control_in                = b;
                  push_c.count              = 2'd1;
                  push_c.res0.kind          = sfr_pkg::KIND_DISC;
                  push_c.res0.reply_control = sfr_pkg::CTRL_DISC;
                  push_c.res0.last          = 1'b1;
               end
            end
            sfr_pkg::ST_CTRL: begin
               if (bcc1_ok) begin
                  held_valid_in = 1'b0;
                  held_byte_in  = '0;
                  xor_in        = '0;
                  count_in      = '0;
               end
            end
            sfr_pkg::ST_DATA, sfr_pkg::ST_ESC: begin
               if ((state_ff == sfr_pkg::ST_DATA) && (b == sfr_pkg::ESC_BYTE)) begin
                  // wait for the second byte of the escape
               end else if ((state_ff == sfr_pkg::ST_DATA) && (b == sfr_pkg::FLAG_BYTE)) begin
                  // closing flag: the held byte is BCC2
                  push_c.count             = 2'd1;
                  push_c.res0.frame_length = count_ff;
                  push_c.res0.frame_seq    = control_ff[6];
                  push_c.res0.last         = 1'b1;
                  if (held_valid_ff && (held_byte_ff == xor_ff)) begin
                     push_c.res0.kind          = sfr_pkg::KIND_GOOD;
                     push_c.res0.reply_control = {reply_seq_ff, sfr_pkg::RR_BASE};
                     reply_seq_in              = !reply_seq_ff;
                  end else begin
                     push_c.res0.kind = sfr_pkg::KIND_ERROR;
                  end
                  held_valid_in = 1'b0;
               end else if ((state_ff == sfr_pkg::ST_ESC) && !esc_ok) begin
                  // bad escape: pass the held byte and the escape byte, hold this byte
                  if (held_valid_ff) begin
                     push_c.count             = 2'd2;
                     push_c.res0.kind         = sfr_pkg::KIND_PAYLOAD;
                     push_c.res0.payload_byte = held_byte_ff;
                     push_c.res1.kind         = sfr_pkg::KIND_PAYLOAD;
                     push_c.res1.payload_byte = sfr_pkg::ESC_BYTE;
                     push_c.res1.last         = 1'b1;
                     xor_in   = xor_ff ^ held_byte_ff ^ sfr_pkg::ESC_BYTE;
                     count_in = sfr_pkg::sat_inc(sfr_pkg::sat_inc(count_ff));
                  end else begin
                     push_c.count             = 2'd1;
                     push_c.res0.kind         = sfr_pkg::KIND_PAYLOAD;
                     push_c.res0.payload_byte = sfr_pkg::ESC_BYTE;
                     push_c.res0.last         = 1'b1;
                     xor_in   = xor_ff ^ sfr_pkg::ESC_BYTE;
                     count_in = sfr_pkg::sat_inc(count_ff);
                  end
                  held_byte_in  = b;
                  held_valid_in = 1'b1;
               end else begin
                  // ordinary or destuffed byte: release the held one
                  if (held_valid_ff) begin
                     push_c.count             = 2'd1;
                     push_c.res0.kind         = sfr_pkg::KIND_PAYLOAD;
                     push_c.res0.payload_byte = held_byte_ff;
                     push_c.res0.last         = 1'b1;
                     xor_in   = xor_ff ^ held_byte_ff;
                     count_in = sfr_pkg::sat_inc(count_ff);
                  end
                  held_byte_in  = push_value;
                  held_valid_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= sfr_pkg::ST_HUNT;
         control_ff    <= '0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         xor_ff        <= '0;
         count_ff      <= '0;
         reply_seq_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         control_ff    <= control_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         xor_ff        <= xor_in;
         count_ff      <= count_in;
         reply_seq_ff  <= reply_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   assign push = push_c;

endmodule

### rtl/sfr_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one per transaction.
// Depends on sfr_pkg and the assertion macros in stuffed_frame_receiver_top_assert.svh.
`include "stuffed_frame_receiver_top_assert.svh"

module sfr_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  sfr_pkg::push_type  push,
   output logic               queue_room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfr_pkg::rsp_type   rsp
);

   sfr_pkg::rsp_type              entry_ff [sfr_pkg::QUEUE_DEPTH];
   logic [sfr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sfr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sfr_pkg::QCNT_W-1:0]    fill_ff, fill_in;
   logic [sfr_pkg::QPTR_W-1:0]    wr_ptr_next;
   logic                          pop;

   assign rsp_valid   = (fill_ff != '0);
   assign pop         = rsp_valid && !rsp_stall;
   assign queue_room  = fill_ff <= sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign rsp         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sfr_pkg::QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + sfr_pkg::QPTR_W'(pop);
      fill_in   = fill_ff + sfr_pkg::QCNT_W'(push.count) - sfr_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.res1;
      end
   end

   `SFR_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH), "result queue overfilled")
   `SFR_ASSERT_NOW(a_push_room, clock, reset, push.count != 2'd0,
      queue_room, "results pushed without room")
   `SFR_ASSERT_NEXT(a_push_shows, clock, reset, push.count != 2'd0,
      rsp_valid, "pushed result not presented")
   `SFR_ASSERT_NOW(a_pair_last, clock, reset, push.count == 2'd2,
      push.res1.last && !push.res0.last, "last flag misplaced on result pair")

endmodule

### rtl/stuffed_frame_receiver_top.sv
// Stuffed frame receiver: one link byte per transaction, up to two results each.
// A byte accepted into the input register is parsed and written to the result queue, which drives rsp_.
// Throughput: one byte per cycle while results drain; the four-entry result queue
// stalls the input register when it has room for fewer than two results.
// Reset (synchronous, active high): parser hunts for a flag, counters and queue
// clear, frame_address returns to 0x03 and reply_address to 0x01.
module stuffed_frame_receiver_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [sfr_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic [sfr_pkg::LEN_W-1:0]        rsp_frame_length,
   output logic                             rsp_frame_seq,
   output logic [sfr_pkg::BYTE_W-1:0]       rsp_reply_control,
   output logic                             rsp_last,
   input  logic                             csr_write,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]       csr_wdata
);

   sfr_pkg::cfg_type  cfg;
   sfr_pkg::push_type push;
   sfr_pkg::rsp_type  rsp;
   logic              queue_room;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg),
      .queue_room  (queue_room),
      .push        (push)
   );

   sfr_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_frame_length  = rsp.frame_length;
   assign rsp_frame_seq     = rsp.frame_seq;
   assign rsp_reply_control = rsp.reply_control;
   assign rsp_last          = rsp.last;

endmodule

### test/stuffed_frame_receiver_top_test.sv
`timescale 1ns / 100ps
// Self-checking test of stuffed_frame_receiver_top: drives link bytes, tracks the
// expected deframer results in a scoreboard class. Depends on sfr_pkg and the RTL.
module stuffed_frame_receiver_top_test;

   localparam int MAX_SHOWN    = 10;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_SLACK  = 8;
   localparam int PHASES       = 6;
   localparam int PHASE_BYTES  = 240;
   localparam int RANDOM_PHASE = 3;

   localparam logic [sfr_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [sfr_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;

   // Disconnect, flag in the control slot then an empty frame, a good frame through
   // the reply address with escapes, then a frame with a wrong check byte.
   localparam logic [7:0] OPENING [27] = '{
      sfr_pkg::FLAG_BYTE, 8'h03, sfr_pkg::CTRL_DISC,
      sfr_pkg::FLAG_BYTE, 8'h03, sfr_pkg::FLAG_BYTE, 8'h03, sfr_pkg::CTRL_I0, 8'h03,
      sfr_pkg::FLAG_BYTE,
      sfr_pkg::FLAG_BYTE, 8'h03, sfr_pkg::CTRL_I1, 8'h41, sfr_pkg::ESC_BYTE,
      sfr_pkg::ESC_FLAG, sfr_pkg::ESC_BYTE, 8'h11, 8'h12,
      sfr_pkg::FLAG_BYTE,
      sfr_pkg::FLAG_BYTE, 8'h03, sfr_pkg::CTRL_I0, 8'h03, 8'hFF, 8'h00,
      sfr_pkg::FLAG_BYTE
   };

   localparam logic [7:0] FRAME_SETTINGS [PHASES] =
      '{8'h00, 8'hFF, 8'h7E, 8'h03, 8'h7D, 8'h03};
   localparam logic [7:0] REPLY_SETTINGS [PHASES] =
      '{8'hFF, 8'h00, 8'h7D, 8'h01, 8'h7E, 8'h01};
   localparam int GAP_SETTINGS [PHASES]   = '{25, 0, 40, 15, 30, 0};
   localparam int STALL_SETTINGS [PHASES] = '{25, 40, 0, 15, 30, 0};

   class frame_tracker;
      sfr_pkg::cfg_type         regs;
      sfr_pkg::parse_state_type state;
      logic [7:0]               ctrl_byte;
      logic [7:0]               held;
      logic                     held_ok;
      logic [7:0]               xor_sum;
      logic [15:0]              count;
      logic                     seq_bit;
      sfr_pkg::rsp_type         due_results[$];
      sfr_pkg::rsp_type         fresh[$];
      int                       fail_count;

      function new();
         regs.frame_address = sfr_pkg::FRAME_ADDRESS_RESET;
         regs.reply_address = sfr_pkg::REPLY_ADDRESS_RESET;
         state      = sfr_pkg::ST_HUNT;
         ctrl_byte  = '0;
         held       = '0;
         held_ok    = 1'b0;
         xor_sum    = '0;
         count      = '0;
         seq_bit    = 1'b0;
         fail_count = 0;
      endfunction

      function void set_reg(logic [sfr_pkg::CSR_INDEX_W-1:0] index, logic [7:0] value);
         case (index)
            sfr_pkg::CSR_FRAME_ADDRESS: regs.frame_address = value;
            sfr_pkg::CSR_REPLY_ADDRESS: regs.reply_address = value;
            default: ;
         endcase
      endfunction

      function void add(sfr_pkg::kind_type k, logic [7:0] pay, logic [15:0] len, logic s,
                        logic [7:0] reply);
         sfr_pkg::rsp_type r;
         r.kind          = k;
         r.payload_byte  = pay;
         r.frame_length  = len;
         r.frame_seq     = s;
         r.reply_control = reply;
         r.last          = 1'b0;
         fresh.push_back(r);
      endfunction

      // Release the held byte as payload and hold the new one.
      function void shift_in(logic [7:0] b);
         if (held_ok) begin
            add(sfr_pkg::KIND_PAYLOAD, held, '0, 1'b0, '0);
            xor_sum ^= held;
            if (count != sfr_pkg::LEN_MAX) count++;
         end
         held    = b;
         held_ok = 1'b1;
      endfunction

      function void take_byte(logic [7:0] b);
         fresh.delete();
         case (state)
            sfr_pkg::ST_HUNT: if (b == sfr_pkg::FLAG_BYTE) state = sfr_pkg::ST_FLAG;
            sfr_pkg::ST_FLAG: begin
               if (b == regs.frame_address) state = sfr_pkg::ST_ADDR;
               else if (b != sfr_pkg::FLAG_BYTE) state = sfr_pkg::ST_HUNT;
            end
            sfr_pkg::ST_ADDR: begin
               if (b == sfr_pkg::CTRL_I0 || b == sfr_pkg::CTRL_I1) begin
                  ctrl_byte = b;
                  state     = sfr_pkg::ST_CTRL;
               end else if (b == sfr_pkg::FLAG_BYTE) begin
                  state = sfr_pkg::ST_FLAG;
               end else if (b == sfr_pkg::CTRL_DISC) begin
                  ctrl_byte = b;
                  add(sfr_pkg::KIND_DISC, '0, '0, 1'b0, sfr_pkg::CTRL_DISC);
                  state = sfr_pkg::ST_HUNT;
               end else begin
                  state = sfr_pkg::ST_HUNT;
               end
            end
            sfr_pkg::ST_CTRL: begin
               if (b == (regs.frame_address ^ ctrl_byte) ||
                   b == (regs.reply_address ^ ctrl_byte)) begin
                  held_ok = 1'b0;
                  held    = '0;
                  xor_sum = '0;
                  count   = '0;
                  state   = sfr_pkg::ST_DATA;
               end else if (b == sfr_pkg::FLAG_BYTE) begin
                  state = sfr_pkg::ST_FLAG;
               end else begin
                  state = sfr_pkg::ST_HUNT;
               end
            end
            sfr_pkg::ST_DATA: begin
               if (b == sfr_pkg::ESC_BYTE) begin
                  state = sfr_pkg::ST_ESC;
               end else if (b == sfr_pkg::FLAG_BYTE) begin
                  if (held_ok && held == xor_sum) begin
                     add(sfr_pkg::KIND_GOOD, '0, count, ctrl_byte[6],
                         {seq_bit, sfr_pkg::RR_BASE});
                     seq_bit = ~seq_bit;
                  end else begin
                     add(sfr_pkg::KIND_ERROR, '0, count, ctrl_byte[6], '0);
                  end
                  held_ok = 1'b0;
                  state   = sfr_pkg::ST_HUNT;
               end else begin
                  shift_in(b);
               end
            end
            sfr_pkg::ST_ESC: begin
               state = sfr_pkg::ST_DATA;
               if (b == sfr_pkg::ESC_FLAG || b == sfr_pkg::ESC_ESC) begin
                  shift_in(b ^ sfr_pkg::STUFF_XOR);
               end else begin
                  shift_in(sfr_pkg::ESC_BYTE);
                  shift_in(b);
               end
            end
            default: state = sfr_pkg::ST_HUNT;
         endcase
         if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) due_results.push_back(fresh[i]);
      endfunction

      function string show(sfr_pkg::rsp_type r);
         return $sformatf("kind=%0d byte=%02h len=%0d seq=%0d reply=%02h last=%0d",
                          r.kind, r.payload_byte, r.frame_length, r.frame_seq,
                          r.reply_control, r.last);
      endfunction

      function void check_result(sfr_pkg::rsp_type got);
         sfr_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            if (fail_count < MAX_SHOWN) $display("unexpected result: %s", show(got));
            fail_count++;
            return;
         end
         want = due_results.pop_front();
         if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
             got.frame_length !== want.frame_length || got.frame_seq !== want.frame_seq ||
             got.reply_control !== want.reply_control || got.last !== want.last) begin
            if (fail_count < MAX_SHOWN) begin
               $display("result mismatch: expected %s", show(want));
               $display("                 actual   %s", show(got));
            end
            fail_count++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   logic [sfr_pkg::BYTE_W-1:0]      req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   logic [1:0]                      rsp_kind;
   logic [sfr_pkg::BYTE_W-1:0]      rsp_payload_byte;
   logic [sfr_pkg::LEN_W-1:0]       rsp_frame_length;
   logic                            rsp_frame_seq;
   logic [sfr_pkg::BYTE_W-1:0]      rsp_reply_control;
   logic                            rsp_last;
   logic                            csr_write   = 1'b0;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [sfr_pkg::BYTE_W-1:0]      csr_wdata   = '0;

   frame_tracker tracker;
   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;
   int sent_count = 0;

   stuffed_frame_receiver_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_reply_control (rsp_reply_control),
      .rsp_last          (rsp_last),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver back-pressure in bursts of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
         stall_left = $urandom_range(1, 8);
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      sfr_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.kind          = sfr_pkg::kind_type'(rsp_kind);
            got.payload_byte  = rsp_payload_byte;
            got.frame_length  = rsp_frame_length;
            got.frame_seq     = rsp_frame_seq;
            got.reply_control = rsp_reply_control;
            got.last          = rsp_last;
            tracker.check_result(got);
         end
         if (req_valid && !req_stall) tracker.take_byte(req_rx_byte);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send(input logic [7:0] b);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_stuffed(input logic [7:0] b);
      if (b == sfr_pkg::FLAG_BYTE || b == sfr_pkg::ESC_BYTE) begin
         send(sfr_pkg::ESC_BYTE);
         send(b ^ sfr_pkg::STUFF_XOR);
      end else begin
         send(b);
      end
   endtask

   // Send a frame with n payload symbols; a few are raw escape pairs that pass
   // through as two bytes. Without a check byte the frame closes empty.
   task automatic send_frame(input int n, input bit has_check, input bit corrupt,
                             input bit alt_addr, input bit seq1);
      logic [7:0] ctrl;
      logic [7:0] sum;
      logic [7:0] d;
      ctrl = seq1 ? sfr_pkg::CTRL_I1 : sfr_pkg::CTRL_I0;
      sum  = '0;
      send(sfr_pkg::FLAG_BYTE);
      send(tracker.regs.frame_address);
      send(ctrl);
      send((alt_addr ? tracker.regs.reply_address : tracker.regs.frame_address) ^ ctrl);
      if (has_check) begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               do d = 8'($urandom); while (d == sfr_pkg::ESC_FLAG || d == sfr_pkg::ESC_ESC);
               send(sfr_pkg::ESC_BYTE);
               send(d);
               sum ^= sfr_pkg::ESC_BYTE ^ d;
            end else begin
               d = 8'($urandom);
               send_stuffed(d);
               sum ^= d;
            end
         end
         if (corrupt) sum ^= 8'(1 << $urandom_range(0, 7));
         send_stuffed(sum);
      end
      send(sfr_pkg::FLAG_BYTE);
   endtask

   // Hold the sender until every expected result is back, then let the pipe settle.
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.due_results.size() != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sfr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [7:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.set_reg(index, value);
      @(posedge clock);
   endtask

   initial begin
      int mark;
      int r;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      gap_pct   = 20;
      stall_pct = 20;
      foreach (OPENING[i]) send(OPENING[i]);
      wait_drain();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(sfr_pkg::CSR_FRAME_ADDRESS,
                   p == RANDOM_PHASE ? 8'($urandom) : FRAME_SETTINGS[p]);
         write_reg(sfr_pkg::CSR_REPLY_ADDRESS,
                   p == RANDOM_PHASE ? 8'($urandom) : REPLY_SETTINGS[p]);
         if (p == 1) begin
            write_reg(CSR_UNUSED_LO, 8'($urandom));
            write_reg(CSR_UNUSED_HI, 8'($urandom));
         end
         gap_pct   = GAP_SETTINGS[p];
         stall_pct = STALL_SETTINGS[p];
         mark      = sent_count;
         while (sent_count - mark < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               send_frame($urandom_range(0, 3) == 0 ? $urandom_range(13, 48)
                                                     : $urandom_range(0, 12),
                          1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 65) begin
               send_frame($urandom_range(0, 8), 1'b1, 1'b1,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 70) begin
               send_frame(0, 1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 78) begin
               send(sfr_pkg::FLAG_BYTE);
               send(tracker.regs.frame_address);
               send(sfr_pkg::CTRL_DISC);
            end else if (r < 88) begin
               // Broken header: flag, maybe the address, then junk.
               send(sfr_pkg::FLAG_BYTE);
               if ($urandom_range(0, 1) == 1) send(tracker.regs.frame_address);
               repeat ($urandom_range(1, 2)) send(8'($urandom));
            end else if (r < 97) begin
               repeat ($urandom_range(1, 6)) send(8'($urandom));
            end else if (p != PHASES - 1) begin
               // keep the final phase free of idle cycles
               wait_drain();
            end
         end
         wait_drain();
      end

      if (tracker.fail_count == 0 && tracker.due_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
